FILE: rtl/core/piea_pkg.sv
// ----------------------------------------------------------------------------
// piea_pkg
// Shared types, constants and helpers for the positional insert/erase array.
// ----------------------------------------------------------------------------
package piea_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IO_WIDTH   = 32;
  localparam int POS_W      = 5;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int WIDE_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [IO_WIDTH-1:0]   io_word_t;
  typedef logic [WIDE_W-1:0]     wide_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;

  localparam wide_t CAP_WIDE = WIDE_W'(CAPACITY);

  typedef enum logic [3:0] {
    REQ_READ_AT    = 4'd0,
    REQ_FRONT      = 4'd1,
    REQ_BACK       = 4'd2,
    REQ_PUSH_BACK  = 4'd3,
    REQ_PUSH_FRONT = 4'd4,
    REQ_POP_BACK   = 4'd5,
    REQ_POP_FRONT  = 4'd6,
    REQ_INSERT     = 4'd7,
    REQ_ERASE      = 4'd8,
    REQ_REMOVE_ALL = 4'd9,
    REQ_FILL       = 4'd10,
    REQ_CLEAR      = 4'd11,
    REQ_RESIZE     = 4'd12,
    REQ_ASSIGN     = 4'd13
  } req_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ERASE,
    CELL_FILL
  } cell_op_t;

  // Command broadcast to every cell of the chain at once.
  typedef struct packed {
    cell_op_t op;
    wide_t    lo;
    wide_t    hi;
    word_t    data;
  } cell_cmd_t;

  typedef enum logic {
    CTRL_IDLE,
    CTRL_SCAN
  } ctrl_state_t;

  function automatic word_t to_word(input io_word_t v);
    return word_t'(v);
  endfunction

  function automatic io_word_t to_io(input word_t w);
    return io_word_t'(w);
  endfunction

endpackage

FILE: rtl/core/piea_cell.sv
// ----------------------------------------------------------------------------
// piea_cell
// One storage cell of the chain. It holds one element and, on command,
// takes the word of its lower or upper neighbor or loads broadcast data.
// ----------------------------------------------------------------------------
module piea_cell (
  input  logic                 clk,
  input  piea_pkg::wide_t      cell_index,
  input  piea_pkg::cell_cmd_t  cmd,
  input  piea_pkg::word_t      from_below,
  input  piea_pkg::word_t      from_above,
  output piea_pkg::word_t      q
);
  import piea_pkg::*;

  word_t q_next;

  always_comb begin
    q_next = q;
    unique case (cmd.op)
      CELL_HOLD: begin
        q_next = q;
      end
      CELL_INSERT: begin
        // Cells above the insert point move up by one place.
        if (cell_index > cmd.lo) begin
          q_next = from_below;
        end else if (cell_index == cmd.lo) begin
          q_next = cmd.data;
        end
      end
      CELL_ERASE: begin
        if (cell_index >= cmd.lo) begin
          q_next = from_above;
        end
      end
      CELL_FILL: begin
        if ((cell_index >= cmd.lo) && (cell_index < cmd.hi)) begin
          q_next = cmd.data;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

FILE: rtl/core/piea_ctrl.sv
// ----------------------------------------------------------------------------
// piea_ctrl
// Request decode, fill count, remove-all scan sequencer and result register.
// ----------------------------------------------------------------------------
module piea_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  logic [3:0]              req_type,
  input  logic [4:0]              position,
  input  piea_pkg::io_word_t      value,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output piea_pkg::io_word_t      read_data,
  output logic [1:0]              status,
  output logic [4:0]              fill_count,
  input  piea_pkg::word_t         cell_q [piea_pkg::CAPACITY],
  output piea_pkg::cell_cmd_t     cmd
);
  import piea_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  logic              pend_valid;
  logic [3:0]        pend_type;
  logic [POS_W-1:0]  pend_pos;
  word_t             pend_value;

  cnt_t              count;
  cnt_t              count_next;
  wide_t             scan_idx;
  wide_t             scan_idx_next;

  logic              accept;
  logic              fire;
  logic              out_free;
  idx_t              rd_addr;
  word_t             rd_word;
  wide_t             cnt_w;
  wide_t             pos_w;
  status_t           res_status;
  io_word_t          res_data;

  assign accept   = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;
  assign cnt_w    = wide_t'(count);
  assign pos_w    = wide_t'(pend_pos);
  assign rd_word  = cell_q[rd_addr];

  // A held transaction leaves the buffer in the same cycle that it retires,
  // so a new one can enter behind it.
  assign req_stall = pend_valid && !fire;

  always_comb begin
    state_next = state;
    unique case (state)
      CTRL_IDLE: begin
        if (pend_valid && (pend_type == REQ_REMOVE_ALL)) begin
          state_next = CTRL_SCAN;
        end
      end
      CTRL_SCAN: begin
        if ((scan_idx >= cnt_w) && out_free) begin
          state_next = CTRL_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    cmd           = '{op: CELL_HOLD, lo: '0, hi: '0, data: pend_value};
    count_next    = count;
    scan_idx_next = scan_idx;
    fire          = 1'b0;
    res_status    = STATUS_OK;
    res_data      = '0;
    rd_addr       = '0;

    unique case (state)
      CTRL_IDLE: begin
        unique case (pend_type)
          REQ_READ_AT: rd_addr = idx_t'(pos_w);
          REQ_BACK:    rd_addr = idx_t'(cnt_w - wide_t'(1));
          default:     rd_addr = '0;
        endcase

        if (pend_valid && (pend_type == REQ_REMOVE_ALL)) begin
          scan_idx_next = '0;
        end else if (pend_valid && out_free) begin
          fire = 1'b1;
          unique case (pend_type)
            REQ_READ_AT: begin
              if (pos_w >= cnt_w) begin
                res_status = STATUS_RANGE;
              end else begin
                res_data = to_io(rd_word);
              end
            end
            REQ_FRONT, REQ_BACK: begin
              if (count == '0) begin
                res_status = STATUS_EMPTY;
              end else begin
                res_data = to_io(rd_word);
              end
            end
            REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
              if (cnt_w >= CAP_WIDE) begin
                res_status = STATUS_FULL;
              end else begin
                cmd.op     = CELL_INSERT;
                cmd.lo     = (pend_type == REQ_PUSH_BACK) ? cnt_w : '0;
                count_next = cnt_t'(count + 1'b1);
              end
            end
            REQ_POP_BACK, REQ_POP_FRONT: begin
              if (count == '0) begin
                res_status = STATUS_EMPTY;
              end else begin
                if (pend_type == REQ_POP_FRONT) begin
                  cmd.op = CELL_ERASE;
                  cmd.lo = '0;
                end
                count_next = cnt_t'(count - 1'b1);
              end
            end
            REQ_INSERT: begin
              if (pos_w > cnt_w) begin
                res_status = STATUS_RANGE;
              end else if (cnt_w >= CAP_WIDE) begin
                res_status = STATUS_FULL;
              end else begin
                cmd.op     = CELL_INSERT;
                cmd.lo     = pos_w;
                count_next = cnt_t'(count + 1'b1);
              end
            end
            REQ_ERASE: begin
              if (pos_w >= cnt_w) begin
                res_status = STATUS_RANGE;
              end else begin
                cmd.op     = CELL_ERASE;
                cmd.lo     = pos_w;
                count_next = cnt_t'(count - 1'b1);
              end
            end
            REQ_FILL: begin
              cmd.op = CELL_FILL;
              cmd.lo = '0;
              cmd.hi = cnt_w;
            end
            REQ_CLEAR: begin
              count_next = '0;
            end
            REQ_RESIZE, REQ_ASSIGN: begin
              if (pos_w > CAP_WIDE) begin
                res_status = STATUS_FULL;
              end else begin
                cmd.op = CELL_FILL;
                // Resize zero-fills only the new slots; assign overwrites all.
                if (pend_type == REQ_RESIZE) begin
                  cmd.lo   = cnt_w;
                  cmd.data = '0;
                end else begin
                  cmd.lo = '0;
                end
                cmd.hi     = pos_w;
                count_next = cnt_t'(pend_pos);
              end
            end
            default: begin
              res_status = STATUS_OK;
            end
          endcase
        end
      end
      CTRL_SCAN: begin
        rd_addr = idx_t'(scan_idx);
        if (scan_idx < cnt_w) begin
          // A match is erased in place and the same index is looked at again.
          if (rd_word == pend_value) begin
            cmd.op     = CELL_ERASE;
            cmd.lo     = scan_idx;
            count_next = cnt_t'(count - 1'b1);
          end else begin
            scan_idx_next = wide_t'(scan_idx + 1'b1);
          end
        end else if (out_free) begin
          fire = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CTRL_IDLE;
      pend_valid <= 1'b0;
      count      <= '0;
      scan_idx   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      scan_idx <= scan_idx_next;
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (fire) begin
        pend_valid <= 1'b0;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_type  <= req_type;
      pend_pos   <= position;
      pend_value <= to_word(value);
    end
    if (fire) begin
      read_data  <= res_data;
      status     <= res_status;
      fill_count <= 5'(count_next);
    end
  end

endmodule

FILE: rtl/core/positional_insert_erase_array_top.sv
// ----------------------------------------------------------------------------
// positional_insert_erase_array_top
// Bounded ordered array of signed words held in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Each request transaction returns exactly one result transaction carrying
// the read data, a status and the fill count after the request. A request
// is taken into a one-entry holding register and retires in the next cycle
// when the result register is free, so all requests but remove_all run at
// one per cycle while the result channel does not stall: insert, erase, the
// pushes and pop_front shift the chain in parallel, pop_back only lowers
// the count, and fill, resize and assign load a range of cells at once.
// Remove_all is run by a scan sequencer that looks at one cell per cycle
// and erases a match in place by shifting the chain down; no other request
// enters the cells meanwhile. The element store is not cleared at reset.
// ----------------------------------------------------------------------------
module positional_insert_erase_array_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [3:0]         req_type,
  input  logic [4:0]         position,
  input  logic signed [31:0] value,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] read_data,
  output logic [1:0]         status,
  output logic [4:0]         fill_count
);
  import piea_pkg::*;

  word_t     cell_q [CAPACITY];
  cell_cmd_t cmd;
  io_word_t  read_data_u;

  assign read_data = read_data_u;

  piea_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .position   (position),
    .value      (io_word_t'(value)),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .read_data  (read_data_u),
    .status     (status),
    .fill_count (fill_count),
    .cell_q     (cell_q),
    .cmd        (cmd)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t below;
    word_t above;

    if (i == 0) begin : g_bottom
      assign below = '0;
    end else begin : g_mid_below
      assign below = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign above = '0;
    end else begin : g_mid_above
      assign above = cell_q[i+1];
    end

    piea_cell u_cell (
      .clk        (clk),
      .cell_index (wide_t'(i)),
      .cmd        (cmd),
      .from_below (below),
      .from_above (above),
      .q          (cell_q[i])
    );
  end

endmodule

FILE: rtl/core/piea_checker.sv
// ----------------------------------------------------------------------------
// piea_checker
// Port-level checks on the result channel of the array block.
// ----------------------------------------------------------------------------
module piea_checker (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input logic signed [31:0] read_data,
  input logic [1:0]         status,
  input logic [4:0]         fill_count
);
  import piea_pkg::*;

  // A stalled result transaction keeps its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data) && $stable(status)
      && $stable(fill_count))
    else $error("result changed while stalled");

  // Only a successful read returns data.
  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != STATUS_OK) |-> read_data == '0)
    else $error("read data returned with an error status");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> fill_count <= CAPACITY)
    else $error("fill count beyond capacity");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind positional_insert_erase_array_top piea_checker u_piea_checker (.*);
